### rtl/ldq_pkg.sv
// Shared constants, operation codes and status codes for the linear array deque.
`timescale 1ns / 1ps
`default_nettype none
package ldq_pkg;

  localparam int DEPTH  = 8;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = 32;

  typedef logic [ADDR_W-1:0] slot_t;
  typedef logic [WORD_W-1:0] word_t;
  typedef logic [2:0]        op_t;
  typedef logic [2:0]        status_t;

  localparam slot_t LAST_SLOT = slot_t'(DEPTH - 1);

  localparam op_t OP_PUSH_FRONT = 3'd0;
  localparam op_t OP_PUSH_BACK  = 3'd1;
  localparam op_t OP_POP_FRONT  = 3'd2;
  localparam op_t OP_POP_BACK   = 3'd3;
  localparam op_t OP_READ_ALL   = 3'd4;

  localparam status_t ST_OK        = 3'd0;
  localparam status_t ST_NO_FRONT  = 3'd1;
  localparam status_t ST_FULL_BACK = 3'd2;
  localparam status_t ST_UNDERFLOW = 3'd3;
  localparam status_t ST_EMPTY     = 3'd4;

endpackage
`default_nettype wire

### rtl/ldq_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module ldq_ram #(
  parameter int WIDTH  = 32,
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/linear_array_deque.sv
// Top level of the linear array deque: end pointers, operation decode and readout sequencer.
//
// Usage: drive operation and value and raise start; the command is taken at a rising
// edge where start is high and busy is low. Every result transaction appears on status,
// data and last for exactly one cycle with done high; the receiver cannot stall it.
// Every result is registered: the RAM read register holds it for pops and readout, an
// output register for pushes and errors.
// Throughput: push, pop and error commands can be issued one every cycle; busy stays
// low for them. A read-all command of N elements holds busy high while it streams the
// elements after the first, one element per cycle, set by the single RAM read port;
// no new command is taken until the edge that reads the last element has dropped busy.
// Unknown operation codes are taken and give no result.
// Reset (rst, synchronous) empties the deque with both ends at slot 0 and drops any
// readout in progress; the store contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module linear_array_deque
  import ldq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] value,
  output logic             done,
  output logic      [2:0]  status,
  output logic      [31:0] data,
  output logic             last
);

  localparam logic S_IDLE   = 1'b0;
  localparam logic S_STREAM = 1'b1;

  logic    state, state_next;
  slot_t   front, front_next;
  slot_t   rear, rear_next;
  logic    empty, empty_next;
  slot_t   idx, idx_next;

  logic    res_valid, res_last, res_mem;
  status_t res_status;
  logic    from_mem;

  logic    we, re;
  slot_t   waddr, raddr;
  word_t   rdata;
  logic    accept;

  assign busy   = (state == S_STREAM);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    front_next = front;
    rear_next  = rear;
    empty_next = empty;
    idx_next   = idx;
    we         = 1'b0;
    waddr      = front;
    re         = 1'b0;
    raddr      = front;
    res_valid  = 1'b0;
    res_status = ST_OK;
    res_last   = 1'b1;
    res_mem    = 1'b0;
    if (state == S_STREAM) begin
      re        = 1'b1;
      raddr     = idx;
      res_valid = 1'b1;
      res_mem   = 1'b1;
      res_last  = (idx == rear);
      if (idx == rear) begin
        state_next = S_IDLE;
      end else begin
        idx_next = idx + slot_t'(1);
      end
    end else if (accept) begin
      case (operation)
        OP_PUSH_FRONT: begin
          res_valid = 1'b1;
          if (empty) begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b0;
            we         = 1'b1;
            waddr      = '0;
          end else if (front == '0) begin
            res_status = ST_NO_FRONT;
          end else begin
            front_next = front - slot_t'(1);
            we         = 1'b1;
            waddr      = front - slot_t'(1);
          end
        end
        OP_PUSH_BACK: begin
          res_valid = 1'b1;
          if (empty) begin
            front_next = '0;
            rear_next  = '0;
            empty_next = 1'b0;
            we         = 1'b1;
            waddr      = '0;
          end else if (rear == LAST_SLOT) begin
            res_status = ST_FULL_BACK;
          end else begin
            rear_next = rear + slot_t'(1);
            we        = 1'b1;
            waddr     = rear + slot_t'(1);
          end
        end
        OP_POP_FRONT, OP_POP_BACK: begin
          res_valid = 1'b1;
          if (empty) begin
            res_status = ST_UNDERFLOW;
          end else begin
            re      = 1'b1;
            res_mem = 1'b1;
            raddr   = (operation == OP_POP_FRONT) ? front : rear;
            if (front == rear) begin
              front_next = '0;
              rear_next  = '0;
              empty_next = 1'b1;
            end else if (operation == OP_POP_FRONT) begin
              front_next = front + slot_t'(1);
            end else begin
              rear_next = rear - slot_t'(1);
            end
          end
        end
        OP_READ_ALL: begin
          res_valid = 1'b1;
          if (empty) begin
            res_status = ST_EMPTY;
          end else begin
            re       = 1'b1;
            raddr    = front;
            res_mem  = 1'b1;
            res_last = (front == rear);
            if (front != rear) begin
              state_next = S_STREAM;
              idx_next   = front + slot_t'(1);
            end
          end
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      front    <= '0;
      rear     <= '0;
      empty    <= 1'b1;
      done     <= 1'b0;
      from_mem <= 1'b0;
      status   <= ST_OK;
      last     <= 1'b0;
    end else begin
      state    <= state_next;
      front    <= front_next;
      rear     <= rear_next;
      empty    <= empty_next;
      done     <= res_valid;
      from_mem <= res_mem;
      status   <= res_status;
      last     <= res_last;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
  end

  // Popped and read-out words come straight from the RAM output register.
  assign data = from_mem ? rdata : '0;

  ldq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

endmodule
`default_nettype wire
